/* rtl/core/bsws_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bsws_pkg;

  // field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned ERR_W  = 2;

  // stream packing
  localparam int unsigned S_TDATA_W = 2 * DATA_W;
  localparam int unsigned S_TUSER_W = KIND_W;
  localparam int unsigned OFS_FOUND = DATA_W;
  localparam int unsigned OFS_ERR   = OFS_FOUND + 1;
  localparam int unsigned OFS_OCC   = OFS_ERR + ERR_W;
  localparam int unsigned OFS_EMPTY = OFS_OCC + OCC_W;
  localparam int unsigned OFS_FULL  = OFS_EMPTY + 1;
  localparam int unsigned RES_W     = OFS_FULL + 1;
  localparam int unsigned M_TDATA_W = ((RES_W + 7) / 8) * 8;
  localparam int unsigned M_PAD_W   = M_TDATA_W - RES_W;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH   = 2'd0,
    KIND_POP    = 2'd1,
    KIND_SEARCH = 2'd2
  } kind_e;

  // error codes
  typedef enum logic [ERR_W-1:0] {
    ERR_NONE  = 2'd0,
    ERR_FULL  = 2'd1,
    ERR_EMPTY = 2'd2
  } err_e;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic do_push;
    logic push_err;
    logic do_pop;
    logic pop_err;
    logic scan_start;
    logic scan_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              can_push;
    logic              empty;
    logic              scan_done;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/core/bsws_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module bsws_dp #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bsws_pkg::CAP_W-1:0]      cfg_wdata_i,
  input  wire logic [bsws_pkg::S_TDATA_W-1:0]  s_tdata_i,
  input  wire logic [bsws_pkg::S_TUSER_W-1:0]  s_tuser_i,
  input  wire bsws_pkg::cmd_t                  cmd_i,
  output bsws_pkg::sts_t                       sts_o,
  output logic [bsws_pkg::M_TDATA_W-1:0]       m_tdata_o
);
  import bsws_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CMP_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

  logic [CAP_W-1:0]     cap_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     cnt_dec;
  logic [KIND_W-1:0]    kind_q;
  logic [DATA_W-1:0]    push_q;
  logic [DATA_W-1:0]    key_q;
  err_e                 err_q, err_d;
  logic                 popped_q, popped_d;
  logic                 found_q, found_d;
  logic                 vld_q, vld_d;
  logic [DATA_W-1:0]    rd_data_q;
  logic [DATA_W-1:0]    mem_q [DEPTH];
  logic [M_TDATA_W-1:0] out_q;

  logic [CMP_W-1:0]     cap_ext, cap_eff, cnt_ext;
  logic                 issue;
  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic                 res_full;
  logic                 res_empty;
  logic [DATA_W-1:0]    res_pop;

  // capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // clamp capacity to 1..DEPTH
  always_comb begin
    cap_ext = (cap_q == '0) ? CMP_W'(1) : CMP_W'(cap_q);
    cap_eff = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    cnt_ext = CMP_W'(cnt_q);
  end

  assign cnt_dec = cnt_q - CNT_W'(1);
  assign issue   = (idx_q != cnt_q);

  // status to controller
  assign sts_o.kind      = kind_q;
  assign sts_o.can_push  = (cnt_ext < cap_eff);
  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.scan_done = (idx_q == cnt_q) && !vld_q;

  // operand capture on input transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      push_q <= s_tdata_i[DATA_W-1:0];
      key_q  <= s_tdata_i[S_TDATA_W-1:DATA_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= '0;
    end else if (cmd_i.latch) begin
      kind_q <= s_tuser_i;
    end
  end

  // count, scan index and result flags
  always_comb begin
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    err_d    = err_q;
    popped_d = popped_q;
    found_d  = found_q;
    vld_d    = 1'b0;
    if (cmd_i.latch) begin
      err_d    = ERR_NONE;
      popped_d = 1'b0;
      found_d  = 1'b0;
    end
    if (cmd_i.do_push) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    if (cmd_i.push_err) begin
      err_d = ERR_FULL;
    end
    if (cmd_i.do_pop) begin
      cnt_d    = cnt_dec;
      popped_d = 1'b1;
    end
    if (cmd_i.pop_err) begin
      err_d = ERR_EMPTY;
    end
    if (cmd_i.scan_start) begin
      idx_d   = '0;
      found_d = 1'b0;
    end
    if (cmd_i.scan_step) begin
      if (issue) begin
        idx_d = idx_q + CNT_W'(1);
        vld_d = 1'b1;
      end
      if (vld_q && (rd_data_q == key_q)) begin
        found_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      idx_q    <= '0;
      err_q    <= ERR_NONE;
      popped_q <= 1'b0;
      found_q  <= 1'b0;
      vld_q    <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      idx_q    <= idx_d;
      err_q    <= err_d;
      popped_q <= popped_d;
      found_q  <= found_d;
      vld_q    <= vld_d;
    end
  end

  // entry memory, one write and one registered read
  assign rd_en   = cmd_i.do_pop || (cmd_i.scan_step && issue);
  assign rd_addr = cmd_i.do_pop ? cnt_dec[AW-1:0] : idx_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.do_push) begin
      mem_q[cnt_q[AW-1:0]] <= push_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // result fields
  assign res_full  = (cnt_ext >= cap_eff);
  assign res_empty = (cnt_q == '0);
  assign res_pop   = popped_q ? rd_data_q : '1;

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= {{M_PAD_W{1'b0}}, res_full, res_empty, cnt_ext[OCC_W-1:0],
                err_q, found_q, res_pop};
    end
  end

  assign m_tdata_o = out_q;

endmodule

`default_nettype wire

/* rtl/core/bsws_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module bsws_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_tvalid_i,
  output logic                 s_tready_o,
  output logic                 m_tvalid_o,
  input  wire logic            m_tready_i,
  input  wire bsws_pkg::sts_t  sts_i,
  output bsws_pkg::cmd_t       cmd_o
);
  import bsws_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   mvalid_q, mvalid_d;
  logic   out_free;

  assign s_tready_o = (state_q == ST_IDLE);
  assign m_tvalid_o = mvalid_q;
  assign out_free   = !mvalid_q || m_tready_i;

  // sequencer
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d = ST_DONE;
        case (sts_i.kind)
          KIND_PUSH: begin
            cmd_o.do_push  = sts_i.can_push;
            cmd_o.push_err = !sts_i.can_push;
          end
          KIND_POP: begin
            cmd_o.do_pop  = !sts_i.empty;
            cmd_o.pop_err = sts_i.empty;
          end
          KIND_SEARCH: begin
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end
          default: begin
            // unused code: no operation
          end
        endcase
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    mvalid_d = mvalid_q;
    if (mvalid_q && m_tready_i) begin
      mvalid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      mvalid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/bounded_stack_with_search.sv */
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata: push_value, search_key; tuser: kind
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata: pop_value .. is_full
// cfg       in   cfg_we_i                       cfg_wdata_i: capacity
//
// one item at a time; push, pop and no-op step through the execute and result states,
// search adds a scan state between them: the scan reads one entry
// per cycle through the single read port of the entry memory
// the result waits in an output register; a stalled output holds the block in its
// result state until the register drains
// reset clears the count and sets capacity to 16; entries are not cleared
`timescale 1ns / 1ps
`default_nettype none

module bounded_stack_with_search #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // capacity register
  input  wire logic                            cfg_we_i,
  input  wire logic [bsws_pkg::CAP_W-1:0]      cfg_wdata_i,
  // request stream
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [31:0] push_value, [63:32] search_key
  input  wire logic [bsws_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] kind
  input  wire logic [bsws_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  // result stream
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [31:0] pop_value, [32] found, [34:33] error_code, [39:35] occupancy,
  // [40] is_empty, [41] is_full, [47:42] zero
  output logic [bsws_pkg::M_TDATA_W-1:0]       m_axis_tdata
);
  import bsws_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  bsws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // stack storage, count and scan
  bsws_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tdata_o   (m_axis_tdata)
  );

  // one item in flight: no transfer right after an accepted one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // pop on empty returns all ones and reports an empty stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[OFS_ERR +: ERR_W] == ERR_EMPTY))
    |-> ((m_axis_tdata[DATA_W-1:0] == '1) && m_axis_tdata[OFS_EMPTY]))
    else $error("empty pop result inconsistent");

  // a hit only comes from a search: no error and no popped word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[OFS_FOUND])
    |-> ((m_axis_tdata[OFS_ERR +: ERR_W] == ERR_NONE) &&
         (m_axis_tdata[DATA_W-1:0] == '1)))
    else $error("found flag on a non-search result");

endmodule

`default_nettype wire

/* sim/bsws_checker.sv */
`timescale 1ns / 1ps

module bsws_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [bsws_pkg::CAP_W-1:0]      cfg_wdata_i,
  input  wire logic                            s_axis_tvalid,
  input  wire logic                            s_axis_tready,
  // [31:0] push_value, [63:32] search_key
  input  wire logic [bsws_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] kind
  input  wire logic [bsws_pkg::S_TUSER_W-1:0]  s_axis_tuser,
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [31:0] pop_value, [32] found, [34:33] error_code, [39:35] occupancy,
  // [40] is_empty, [41] is_full, [47:42] zero
  input  wire logic [bsws_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic                            drain_check_i,
  output int unsigned                          fail_count_o,
  output int unsigned                          pending_o
);
  import bsws_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    logic              found;
    err_e              error_code;
    logic [OCC_W-1:0]  occupancy;
    logic              is_empty;
    logic              is_full;
  } stack_result_t;

  // shadow of the stack contents and capacity register
  logic [DATA_W-1:0] held [DEPTH];
  int unsigned       held_count = 0;
  logic [CAP_W-1:0]  cap_reg = CAP_RESET;
  stack_result_t     result_queue [$];
  int unsigned       fails = 0;
  bit                drain_seen = 1'b0;

  // applies one request to the shadow stack, returns the result it must produce
  function automatic stack_result_t apply_request(input logic [KIND_W-1:0] kind,
                                                  input logic [DATA_W-1:0] pv,
                                                  input logic [DATA_W-1:0] key);
    stack_result_t r;
    int unsigned   limit;
    // capacity clamped to 1..DEPTH
    limit = (cap_reg == 0) ? 1 : ((cap_reg > DEPTH) ? DEPTH : cap_reg);
    r.pop_value  = '1;
    r.found      = 1'b0;
    r.error_code = ERR_NONE;
    case (kind)
      KIND_PUSH: begin
        if (held_count >= limit) begin
          r.error_code = ERR_FULL;
        end else begin
          held[held_count] = pv;
          held_count++;
        end
      end
      KIND_POP: begin
        if (held_count == 0) begin
          r.error_code = ERR_EMPTY;
        end else begin
          held_count--;
          r.pop_value = held[held_count];
        end
      end
      KIND_SEARCH: begin
        for (int i = 0; i < held_count; i++) begin
          if (held[i] == key) r.found = 1'b1;
        end
      end
      default: begin
        // unused kind: no operation
      end
    endcase
    r.occupancy = OCC_W'(held_count);
    r.is_empty  = (held_count == 0);
    r.is_full   = (held_count >= limit);
    return r;
  endfunction

  // compare result transfers, then predict request transfers
  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t want;
    stack_result_t got;
    if (!rst_ni) begin
      held_count = 0;
      cap_reg    = CAP_RESET;
      result_queue.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_queue.size() == 0) begin
          $error("unexpected result transfer: tdata %h", m_axis_tdata);
          fails++;
        end else begin
          want = result_queue.pop_front();
          got.pop_value  = m_axis_tdata[DATA_W-1:0];
          got.found      = m_axis_tdata[OFS_FOUND];
          got.error_code = err_e'(m_axis_tdata[OFS_ERR +: ERR_W]);
          got.occupancy  = m_axis_tdata[OFS_OCC +: OCC_W];
          got.is_empty   = m_axis_tdata[OFS_EMPTY];
          got.is_full    = m_axis_tdata[OFS_FULL];
          if (got.pop_value !== want.pop_value) begin
            $error("pop_value mismatch: expected %0d, got %0d",
                   $signed(want.pop_value), $signed(got.pop_value));
            fails++;
          end
          if (got.found !== want.found) begin
            $error("found mismatch: expected %0d, got %0d", want.found, got.found);
            fails++;
          end
          if (got.error_code !== want.error_code) begin
            $error("error_code mismatch: expected %0d, got %0d",
                   want.error_code, got.error_code);
            fails++;
          end
          if (got.occupancy !== want.occupancy) begin
            $error("occupancy mismatch: expected %0d, got %0d",
                   want.occupancy, got.occupancy);
            fails++;
          end
          if (got.is_empty !== want.is_empty) begin
            $error("is_empty mismatch: expected %0d, got %0d",
                   want.is_empty, got.is_empty);
            fails++;
          end
          if (got.is_full !== want.is_full) begin
            $error("is_full mismatch: expected %0d, got %0d", want.is_full, got.is_full);
            fails++;
          end
          if (m_axis_tdata[M_TDATA_W-1:RES_W] !== '0) begin
            $error("padding mismatch: expected 0, got %h", m_axis_tdata[M_TDATA_W-1:RES_W]);
            fails++;
          end
        end
      end

      if (cfg_we_i) cap_reg = cfg_wdata_i;

      if (s_axis_tvalid && s_axis_tready) begin
        result_queue.push_back(apply_request(s_axis_tuser, s_axis_tdata[DATA_W-1:0],
                                             s_axis_tdata[2*DATA_W-1:DATA_W]));
      end

      // results still owed when stimulus is over
      if (drain_check_i && !drain_seen) begin
        drain_seen = 1'b1;
        if (result_queue.size() != 0) begin
          $error("results missing: expected 0 outstanding, got %0d", result_queue.size());
          fails += result_queue.size();
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= result_queue.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;
  import bsws_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned ROUNDS       = 12;
  localparam int unsigned ROUND_LEN    = 160;
  localparam int unsigned QUIET_ROUNDS = 2;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CAP_W-1:0]     cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 drain_check   = 1'b0;
  int unsigned          fail_count;
  int unsigned          pending;

  bit                   quiet = 1'b0;
  int unsigned          rx_hold = 0;
  logic                 rx_level = 1'b1;
  int unsigned          stall_cycles = 0;
  logic [DATA_W-1:0]    word_pool [8];
  int unsigned          extreme_caps [5] = '{16, 1, 0, 31, 17};

  always #10 clk_i = ~clk_i;

  bounded_stack_with_search #(
    .DEPTH (DEPTH)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  bsws_checker #(
    .DEPTH (DEPTH)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .drain_check_i (drain_check),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // result side: ready in random stretches, broken by random stall bursts
  always @(posedge clk_i) begin
    if (rx_hold == 0) begin
      if (quiet) begin
        rx_level = 1'b1;
        rx_hold  = 1;
      end else if ($urandom_range(0, 2) == 0) begin
        rx_level = 1'b0;
        rx_hold  = $urandom_range(1, 14);
      end else begin
        rx_level = 1'b1;
        rx_hold  = $urandom_range(1, 30);
      end
    end
    rx_hold--;
    m_axis_tready <= rx_level;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // words from a small pool so searches hit, or fully random
  function automatic logic [DATA_W-1:0] pick_word();
    if ($urandom_range(0, 1) == 0) return word_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // one request transfer, with a random gap in front of it
  task automatic send_req(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] pv,
                          input logic [DATA_W-1:0] key);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {key, pv};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // hold off requests until every result is back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= cap;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [KIND_W-1:0] kind;
    int unsigned       push_w;
    int unsigned       pop_w;
    int unsigned       search_w;
    int unsigned       pick;

    word_pool[0] = 32'h8000_0000;
    word_pool[1] = 32'h7FFF_FFFF;
    word_pool[2] = 32'h0000_0000;
    word_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 8; i++) word_pool[i] = $urandom;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // small capacity: extremes, refused push, hit and miss, no-op, empty pop
    set_capacity(2);
    send_req(KIND_PUSH, 32'h7FFF_FFFF, $urandom);
    send_req(KIND_PUSH, 32'h8000_0000, $urandom);
    send_req(KIND_PUSH, 32'h0000_0000, $urandom);
    send_req(KIND_SEARCH, $urandom, 32'h8000_0000);
    send_req(KIND_SEARCH, $urandom, 32'h7FFF_FFFE);
    send_req(KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_req(KIND_POP, $urandom, $urandom);
    send_req(KIND_POP, $urandom, $urandom);
    send_req(KIND_POP, $urandom, $urandom);
    send_req(KIND_SEARCH, $urandom, 32'h0000_0000);

    // capacity lowered below occupancy keeps entries and reads as full
    set_capacity(16);
    send_req(KIND_PUSH, 32'hFFFF_FFFF, $urandom);
    send_req(KIND_PUSH, 32'h0000_0000, $urandom);
    send_req(KIND_PUSH, 32'h0000_0001, $urandom);
    set_capacity(1);
    send_req(KIND_PUSH, 32'h1234_5678, $urandom);
    send_req(KIND_SEARCH, $urandom, 32'hFFFF_FFFF);
    send_req(KIND_POP, $urandom, $urandom);
    send_req(KIND_POP, $urandom, $urandom);
    send_req(KIND_PUSH, 32'h5555_5555, $urandom);
    send_req(KIND_POP, $urandom, $urandom);

    // zero capacity acts as one, values past the depth act as the depth
    set_capacity(0);
    send_req(KIND_PUSH, 32'hAAAA_AAAA, $urandom);
    send_req(KIND_PUSH, 32'h5555_5555, $urandom);
    send_req(KIND_POP, $urandom, $urandom);
    set_capacity(31);
    send_req(KIND_PUSH, 32'h0F0F_0F0F, $urandom);
    send_req(KIND_SEARCH, $urandom, 32'h0F0F_0F0F);

    // random rounds, each under its own capacity, with shifting operation mix
    for (int round = 0; round < ROUNDS; round++) begin
      if (round < 5) set_capacity(CAP_W'(extreme_caps[round]));
      else set_capacity(CAP_W'($urandom_range(0, 31)));
      quiet <= (round >= ROUNDS - QUIET_ROUNDS);
      for (int n = 0; n < ROUND_LEN; n++) begin
        if (n % 20 == 0) begin
          push_w   = $urandom_range(5, 70);
          pop_w    = $urandom_range(5, 70);
          search_w = $urandom_range(5, 40);
        end
        pick = $urandom_range(1, push_w + pop_w + search_w + 3);
        if (pick <= 3) kind = KIND_NOP;
        else if (pick <= 3 + push_w) kind = KIND_PUSH;
        else if (pick <= 3 + push_w + pop_w) kind = KIND_POP;
        else kind = KIND_SEARCH;
        send_req(kind, pick_word(), pick_word());
      end
    end

    settle();
    repeat (5) @(posedge clk_i);
    drain_check <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
